/* sv/alm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the audio level meter.
// Used by the controller, the datapath, the divider and the top level.
package alm_pkg;

  localparam int LVL_W          = 15;
  localparam int SMP_W          = 16;
  localparam int BLOCK_LEN_DEF  = 64;
  localparam int RING_DEPTH_DEF = 16;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic sample_take;
    logic read_take;
    logic blk_div_start;
    logic ring_div_start;
    logic avg_write;
    logic walk_step;
    logic out_load;
  } alm_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic div_done;
    logic walk_last;
  } alm_sts_t;

endpackage

/* sv/alm_div.sv */
`timescale 1ns / 1ps
// Divide by a constant through a reciprocal multiply: operand registered on start,
// quotient and done the cycle after. Depends on alm_pkg. Dividend below DEN * 2**LVL_W.
module alm_div #(
  parameter int NUM_W = 21,
  parameter int DEN   = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  output logic                      done,
  output logic [alm_pkg::LVL_W-1:0] quo
);
  import alm_pkg::*;

  localparam int DEN_W  = $clog2(DEN);
  localparam int SH     = LVL_W + 2 * DEN_W;
  localparam int RCP_W  = LVL_W + DEN_W + 2;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN));

  logic [NUM_W-1:0]  num_r;
  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0]  quo_r;
  logic              busy_r;
  logic              done_r;

  assign prod = PROD_W'(num_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
    if (start) begin
      num_r <= num;
    end
    if (busy_r) begin
      quo_r <= prod[SH +: LVL_W];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/alm_dp.sv */
`timescale 1ns / 1ps
// Datapath of the audio level meter: block sum, running peak, both rings,
// the ring walk and the result registers. Depends on alm_pkg and alm_div.
module alm_dp #(
  parameter int BLOCK_LEN  = alm_pkg::BLOCK_LEN_DEF,
  parameter int RING_DEPTH = alm_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alm_pkg::alm_cmd_t             cmd,
  output alm_pkg::alm_sts_t             sts,
  input  logic signed [alm_pkg::SMP_W-1:0] in_sample_value,
  output logic [alm_pkg::LVL_W-1:0]     out_avg_level,
  output logic [alm_pkg::LVL_W-1:0]     out_peak_level,
  output logic [alm_pkg::LVL_W-1:0]     out_held_peak,
  output logic                          out_ready_flag
);
  import alm_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = LVL_W + $clog2(BLOCK_LEN);
  localparam int RAW   = $clog2(RING_DEPTH);
  localparam int TOT_W = LVL_W + RAW;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [LVL_W-1:0] peak_r;
  logic [RAW-1:0]   avg_pos_r, peak_pos_r, walk_idx_r;
  logic             avg_full_r, peak_full_r, wrap_r;
  logic [LVL_W-1:0] mag;
  logic [SMP_W-1:0] neg_val;

  logic [LVL_W-1:0] avg_mem [RING_DEPTH];
  logic [LVL_W-1:0] peak_mem [RING_DEPTH];
  logic [LVL_W-1:0] avg_q_r, peak_q_r;
  logic             rd_pend_r, avg_vld_r, peak_vld_r;

  logic [TOT_W-1:0] total_r;
  logic [LVL_W-1:0] held_r, peak_res_r;
  logic             flag_res_r;

  logic             blk_done, ring_done;
  logic [LVL_W-1:0] blk_quo, ring_quo;

  logic [LVL_W-1:0] avg_lvl_r, peak_lvl_r, held_lvl_r;
  logic             ready_r;

  assign neg_val = ~in_sample_value + 1'b1;
  always_comb begin
    if (in_sample_value == {1'b1, {(SMP_W-1){1'b0}}}) begin
      mag = {LVL_W{1'b1}};
    end else if (in_sample_value[SMP_W-1]) begin
      mag = neg_val[LVL_W-1:0];
    end else begin
      mag = in_sample_value[LVL_W-1:0];
    end
  end

  assign sum_nxt = sum_r + SUM_W'(mag);

  alm_div #(
    .NUM_W (SUM_W),
    .DEN   (BLOCK_LEN)
  ) u_blk_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.blk_div_start),
    .num   (sum_nxt),
    .done  (blk_done),
    .quo   (blk_quo)
  );

  alm_div #(
    .NUM_W (TOT_W),
    .DEN   (RING_DEPTH)
  ) u_ring_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ring_div_start),
    .num   (total_r),
    .done  (ring_done),
    .quo   (ring_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      peak_r      <= '0;
      avg_pos_r   <= '0;
      peak_pos_r  <= '0;
      avg_full_r  <= 1'b0;
      peak_full_r <= 1'b0;
      wrap_r      <= 1'b0;
      walk_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.walk_step;
      if (cmd.sample_take) begin
        if (mag > peak_r) begin
          peak_r <= mag;
        end
        if (cmd.blk_div_start) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.avg_write) begin
        if (avg_pos_r == RAW'(RING_DEPTH - 1)) begin
          avg_pos_r  <= '0;
          avg_full_r <= 1'b1;
          wrap_r     <= 1'b1;
        end else begin
          avg_pos_r <= avg_pos_r + 1'b1;
        end
      end
      if (cmd.read_take) begin
        peak_r     <= '0;
        wrap_r     <= 1'b0;
        walk_idx_r <= '0;
        if (peak_pos_r == RAW'(RING_DEPTH - 1)) begin
          peak_pos_r  <= '0;
          peak_full_r <= 1'b1;
        end else begin
          peak_pos_r <= peak_pos_r + 1'b1;
        end
      end else if (cmd.walk_step) begin
        walk_idx_r <= walk_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_write) begin
      avg_mem[avg_pos_r] <= blk_quo;
    end
    if (cmd.read_take) begin
      peak_mem[peak_pos_r] <= peak_r;
    end
    avg_q_r    <= avg_mem[walk_idx_r];
    peak_q_r   <= peak_mem[walk_idx_r];
    avg_vld_r  <= avg_full_r | (walk_idx_r < avg_pos_r);
    peak_vld_r <= peak_full_r | (walk_idx_r < peak_pos_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.read_take) begin
      total_r    <= '0;
      held_r     <= '0;
      peak_res_r <= peak_r;
      flag_res_r <= wrap_r;
    end else if (rd_pend_r) begin
      if (avg_vld_r) begin
        total_r <= total_r + TOT_W'(avg_q_r);
      end
      if (peak_vld_r && (peak_q_r > held_r)) begin
        held_r <= peak_q_r;
      end
    end
    if (cmd.out_load) begin
      avg_lvl_r  <= ring_quo;
      peak_lvl_r <= peak_res_r;
      held_lvl_r <= held_r;
      ready_r    <= flag_res_r;
    end
  end

  assign sts.blk_end   = (cnt_r == CNT_W'(BLOCK_LEN - 1));
  assign sts.div_done  = blk_done | ring_done;
  assign sts.walk_last = (walk_idx_r == RAW'(RING_DEPTH - 1));

  assign out_avg_level  = avg_lvl_r;
  assign out_peak_level = peak_lvl_r;
  assign out_held_peak  = held_lvl_r;
  assign out_ready_flag = ready_r;

endmodule

/* sv/alm_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the audio level meter: sequences samples, block averages,
// ring walks and the output register. Depends on alm_pkg.
module alm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  output logic              out_valid,
  input  logic              out_stall,
  output alm_pkg::alm_cmd_t cmd,
  input  alm_pkg::alm_sts_t sts
);
  import alm_pkg::*;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_BLK_DIV    = 3'd1;
  localparam logic [2:0] S_WALK       = 3'd2;
  localparam logic [2:0] S_WALK_TAIL  = 3'd3;
  localparam logic [2:0] S_RING_START = 3'd4;
  localparam logic [2:0] S_RING_DIV   = 3'd5;
  localparam logic [2:0] S_OUT        = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_SAMPLE) begin
            cmd.sample_take = 1'b1;
            if (sts.blk_end) begin
              cmd.blk_div_start = 1'b1;
              state_nxt         = S_BLK_DIV;
            end
          end else begin
            cmd.read_take = 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end
      S_BLK_DIV: begin
        if (sts.div_done) begin
          cmd.avg_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_WALK_TAIL;
        end
      end
      S_WALK_TAIL: begin
        state_nxt = S_RING_START;
      end
      S_RING_START: begin
        cmd.ring_div_start = 1'b1;
        state_nxt          = S_RING_DIV;
      end
      S_RING_DIV: begin
        if (sts.div_done) begin
          if (out_free) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_BLK_DIV || state_r == S_RING_DIV))
    else $error("divider finished outside a divide state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result loaded over a pending transaction");

  a_read_walks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_take |=> (state_r == S_WALK && in_stall))
    else $error("read transaction did not start the ring walk");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

/* sv/audio_level_meter.sv */
`timescale 1ns / 1ps
// Audio level meter top level. Sample transaction: the sample that closes a
// block stalls the input while the reciprocal multiplier forms the average.
// Read transaction: one-port walk of both rings, then a constant divide, before the
// result is valid; input stalls until the result is loaded.
// No result for samples; one output register lets samples be taken while a result waits.
// Synchronous reset clears sums, peak, ring fill state and flags; rings need no clearing.
module audio_level_meter #(
  parameter int BLOCK_LEN  = alm_pkg::BLOCK_LEN_DEF,
  parameter int RING_DEPTH = alm_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic signed [alm_pkg::SMP_W-1:0] in_sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [alm_pkg::LVL_W-1:0]        out_avg_level,
  output logic [alm_pkg::LVL_W-1:0]        out_peak_level,
  output logic [alm_pkg::LVL_W-1:0]        out_held_peak,
  output logic                             out_ready_flag
);
  import alm_pkg::*;

  alm_cmd_t cmd;
  alm_sts_t sts;

  alm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  alm_dp #(
    .BLOCK_LEN  (BLOCK_LEN),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_value (in_sample_value),
    .out_avg_level   (out_avg_level),
    .out_peak_level  (out_peak_level),
    .out_held_peak   (out_held_peak),
    .out_ready_flag  (out_ready_flag)
  );

endmodule
